/* rtl/core/rfd_pkg.sv */
package rfd_pkg;

  localparam logic [7:0]  START_BYTE  = 8'h02;
  localparam logic [7:0]  END_BYTE    = 8'h03;
  localparam logic [15:0] FIXED_BYTES = 16'd26;
  localparam logic [15:0] WORD_BYTES  = 16'd4;

  localparam logic [15:0] RST_MAX_RID = 16'd49;
  localparam logic [15:0] RST_MAX_SVC = 16'd511;
  localparam logic [15:0] RST_MAX_EI  = 16'd511;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_RID = 2'd0;
  localparam logic [1:0] REG_MAX_SVC = 2'd1;
  localparam logic [1:0] REG_MAX_EI  = 2'd2;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_LEN,
    PH_RIDLEN,
    PH_RID,
    PH_SVCLEN,
    PH_SVC,
    PH_ECODE,
    PH_EILEN,
    PH_EI,
    PH_PAY,
    PH_CK,
    PH_END,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HUNT    = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_RID     = 3'd2,
    KIND_SVC     = 3'd3,
    KIND_EI      = 3'd4,
    KIND_PAYLOAD = 3'd5,
    KIND_TRAILER = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY_RID = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_END_MISS  = 3'd4
  } status_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
  } cls_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        done;
    status_t     status;
    logic [31:0] error_code;
    logic [15:0] payload_length;
  } res_t;

  typedef struct packed {
    logic [15:0] max_rid;
    logic [15:0] max_svc;
    logic [15:0] max_ei;
  } limits_t;

endpackage

/* rtl/core/rfd_fifo.sv */
module rfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/rfd_front.sv */
module rfd_front (
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          cls_valid,
  output rfd_pkg::cls_t cls
);

  // flag the marker bytes ahead of the parser
  always_comb begin
    cls_valid    = push;
    cls.data     = rx_byte;
    cls.is_start = (rx_byte == rfd_pkg::START_BYTE);
    cls.is_end   = (rx_byte == rfd_pkg::END_BYTE);
  end

endmodule

/* rtl/core/rfd_back.sv */
module rfd_back #(
  parameter int MAX_FRAME_LENGTH = 65535
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cls_avail,
  input  rfd_pkg::cls_t    cls,
  output logic             cls_take,
  input  logic             res_full,
  output logic             res_push,
  output rfd_pkg::res_t    res,
  input  rfd_pkg::limits_t limits
);

  localparam logic [31:0] MAX_LEN = 32'(MAX_FRAME_LENGTH);

  rfd_pkg::phase_t  phase_r, phase_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [31:0]      ecode_r, ecode_nxt;
  logic [15:0]      room_r, room_nxt;
  rfd_pkg::status_t status_r, status_nxt;

  logic             fire;
  logic [31:0]      word_cat;
  logic [15:0]      rem_dec;
  logic [15:0]      rem_sat;
  logic [15:0]      pos_inc;
  logic             at_end;
  logic [15:0]      limit;
  rfd_pkg::status_t chk;
  rfd_pkg::status_t end_st;

  assign fire     = cls_avail && !res_full;
  assign cls_take = fire;
  assign res_push = fire;
  assign word_cat = {word_r[23:0], cls.data};
  assign rem_dec  = rem_r - 16'd1;
  assign rem_sat  = (rem_r != '0) ? rem_dec : '0;
  assign pos_inc  = pos_r + 16'd1;
  assign at_end   = ({1'b0, pos_inc} + 17'd1) >= {1'b0, len_r};

  always_comb begin
    unique case (phase_r)
      rfd_pkg::PH_RIDLEN: limit = limits.max_rid;
      rfd_pkg::PH_SVCLEN: limit = limits.max_svc;
      default:            limit = limits.max_ei;
    endcase
    priority if (phase_r == rfd_pkg::PH_RIDLEN && word_cat == '0) begin
      chk = rfd_pkg::ST_EMPTY_RID;
    end else if (word_cat > {16'd0, room_r}) begin
      chk = rfd_pkg::ST_OVERRUN;
    end else if (word_cat > {16'd0, limit}) begin
      chk = rfd_pkg::ST_TOO_LONG;
    end else begin
      chk = rfd_pkg::ST_OK;
    end
    if (status_r != rfd_pkg::ST_OK) begin
      end_st = status_r;
    end else if (cls.is_end) begin
      end_st = rfd_pkg::ST_OK;
    end else begin
      end_st = rfd_pkg::ST_END_MISS;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    word_nxt   = word_r;
    ecode_nxt  = ecode_r;
    room_nxt   = room_r;
    status_nxt = status_r;

    res.kind           = rfd_pkg::KIND_HUNT;
    res.data           = cls.data;
    res.done           = 1'b0;
    res.status         = rfd_pkg::ST_OK;
    res.error_code     = '0;
    res.payload_length = '0;

    unique case (phase_r)
      rfd_pkg::PH_HUNT: begin
        if (cls.is_start) begin
          phase_nxt  = rfd_pkg::PH_LEN;
          rem_nxt    = rfd_pkg::WORD_BYTES;
          word_nxt   = '0;
          pos_nxt    = '0;
          len_nxt    = '0;
          room_nxt   = '0;
          status_nxt = rfd_pkg::ST_OK;
          ecode_nxt  = '0;
          res.kind   = rfd_pkg::KIND_HEADER;
        end
      end
      rfd_pkg::PH_LEN: begin
        pos_nxt  = pos_inc;
        res.kind = rfd_pkg::KIND_HEADER;
        word_nxt = word_cat;
        rem_nxt  = rem_dec;
        if (rem_dec == '0) begin
          if (word_cat < {16'd0, rfd_pkg::FIXED_BYTES} || word_cat > MAX_LEN) begin
            res.done   = 1'b1;
            res.status = rfd_pkg::ST_END_MISS;
            phase_nxt  = rfd_pkg::PH_HUNT;
          end else begin
            len_nxt   = word_cat[15:0];
            room_nxt  = word_cat[15:0] - rfd_pkg::FIXED_BYTES;
            phase_nxt = rfd_pkg::PH_RIDLEN;
            rem_nxt   = rfd_pkg::WORD_BYTES;
            word_nxt  = '0;
          end
        end
      end
      default: begin
        pos_nxt = pos_inc;
        if (at_end) begin
          // last byte of the frame: report and go back to hunting
          res.kind       = rfd_pkg::KIND_TRAILER;
          res.done       = 1'b1;
          res.status     = end_st;
          res.error_code = ecode_r;
          res.payload_length = (end_st == rfd_pkg::ST_OK) ? room_r : '0;
          phase_nxt      = rfd_pkg::PH_HUNT;
        end else begin
          unique case (phase_r)
            rfd_pkg::PH_RIDLEN, rfd_pkg::PH_SVCLEN,
            rfd_pkg::PH_ECODE, rfd_pkg::PH_EILEN: begin
              res.kind = rfd_pkg::KIND_HEADER;
              word_nxt = word_cat;
              rem_nxt  = rem_dec;
              if (rem_dec == '0) begin
                if (phase_r == rfd_pkg::PH_ECODE) begin
                  ecode_nxt = word_cat;
                  phase_nxt = rfd_pkg::PH_EILEN;
                  rem_nxt   = rfd_pkg::WORD_BYTES;
                  word_nxt  = '0;
                end else if (chk != rfd_pkg::ST_OK) begin
                  status_nxt = chk;
                  phase_nxt  = rfd_pkg::PH_SKIP;
                end else begin
                  room_nxt = room_r - word_cat[15:0];
                  if (word_cat == '0) begin
                    if (phase_r == rfd_pkg::PH_SVCLEN) begin
                      phase_nxt = rfd_pkg::PH_ECODE;
                      rem_nxt   = rfd_pkg::WORD_BYTES;
                      word_nxt  = '0;
                    end else if (room_r == '0) begin
                      phase_nxt = rfd_pkg::PH_CK;
                      rem_nxt   = rfd_pkg::WORD_BYTES;
                    end else begin
                      phase_nxt = rfd_pkg::PH_PAY;
                      rem_nxt   = room_r;
                    end
                  end else begin
                    rem_nxt = word_cat[15:0];
                    unique case (phase_r)
                      rfd_pkg::PH_RIDLEN: phase_nxt = rfd_pkg::PH_RID;
                      rfd_pkg::PH_SVCLEN: phase_nxt = rfd_pkg::PH_SVC;
                      default:            phase_nxt = rfd_pkg::PH_EI;
                    endcase
                  end
                end
              end
            end
            rfd_pkg::PH_RID, rfd_pkg::PH_SVC, rfd_pkg::PH_EI, rfd_pkg::PH_PAY: begin
              unique case (phase_r)
                rfd_pkg::PH_RID: res.kind = rfd_pkg::KIND_RID;
                rfd_pkg::PH_SVC: res.kind = rfd_pkg::KIND_SVC;
                rfd_pkg::PH_EI:  res.kind = rfd_pkg::KIND_EI;
                default:         res.kind = rfd_pkg::KIND_PAYLOAD;
              endcase
              rem_nxt = rem_sat;
              if (rem_sat == '0) begin
                unique case (phase_r)
                  rfd_pkg::PH_RID: begin
                    phase_nxt = rfd_pkg::PH_SVCLEN;
                    rem_nxt   = rfd_pkg::WORD_BYTES;
                    word_nxt  = '0;
                  end
                  rfd_pkg::PH_SVC: begin
                    phase_nxt = rfd_pkg::PH_ECODE;
                    rem_nxt   = rfd_pkg::WORD_BYTES;
                    word_nxt  = '0;
                  end
                  rfd_pkg::PH_EI: begin
                    if (room_r == '0) begin
                      phase_nxt = rfd_pkg::PH_CK;
                      rem_nxt   = rfd_pkg::WORD_BYTES;
                    end else begin
                      phase_nxt = rfd_pkg::PH_PAY;
                      rem_nxt   = room_r;
                    end
                  end
                  default: begin
                    phase_nxt = rfd_pkg::PH_CK;
                    rem_nxt   = rfd_pkg::WORD_BYTES;
                  end
                endcase
              end
            end
            rfd_pkg::PH_CK: begin
              res.kind = rfd_pkg::KIND_TRAILER;
              rem_nxt  = rem_sat;
              if (rem_sat == '0) begin
                phase_nxt = rfd_pkg::PH_END;
              end
            end
            default: begin
              res.kind = rfd_pkg::KIND_TRAILER;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rfd_pkg::PH_HUNT;
      len_r    <= '0;
      pos_r    <= '0;
      rem_r    <= '0;
      word_r   <= '0;
      ecode_r  <= '0;
      room_r   <= '0;
      status_r <= rfd_pkg::ST_OK;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      rem_r    <= rem_nxt;
      word_r   <= word_nxt;
      ecode_r  <= ecode_nxt;
      room_r   <= room_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

/* rtl/core/rpc_frame_deframer_unit.sv */
// an accepted byte goes through the input queue and the parser into the result queue
// throughput: one item per cycle while the result queue has room, set by the parser step
// full and empty come straight from the two-entry queues on each side
// reset (rst_n low, synchronous): queues empty, parser hunting for a start byte,
// limits back to 49, 511 and 511
module rpc_frame_deframer_unit #(
  parameter int MAX_FRAME_LENGTH = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  // tagged byte output
  input  logic               pop,
  output logic               empty,
  output logic [2:0]         out_byte_kind,
  output logic [7:0]         out_data_byte,
  output logic               out_frame_done,
  output logic [2:0]         out_frame_status,
  output logic signed [31:0] out_error_code,
  output logic [15:0]        out_payload_length,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CLS_W = $bits(rfd_pkg::cls_t);
  localparam int RES_W = $bits(rfd_pkg::res_t);

  // field length limits
  logic [15:0]      max_rid_r, max_svc_r, max_ei_r;
  rfd_pkg::limits_t limits;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rid_r <= rfd_pkg::RST_MAX_RID;
      max_svc_r <= rfd_pkg::RST_MAX_SVC;
      max_ei_r  <= rfd_pkg::RST_MAX_EI;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rfd_pkg::REG_MAX_RID: max_rid_r <= pwdata[15:0];
        rfd_pkg::REG_MAX_SVC: max_svc_r <= pwdata[15:0];
        rfd_pkg::REG_MAX_EI:  max_ei_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rfd_pkg::REG_MAX_RID: prdata = {16'd0, max_rid_r};
      rfd_pkg::REG_MAX_SVC: prdata = {16'd0, max_svc_r};
      rfd_pkg::REG_MAX_EI:  prdata = {16'd0, max_ei_r};
      default:              prdata = '0;
    endcase
    limits.max_rid = max_rid_r;
    limits.max_svc = max_svc_r;
    limits.max_ei  = max_ei_r;
  end

  // front: classify incoming bytes
  logic          cls_valid;
  rfd_pkg::cls_t cls_in;

  rfd_front u_front (
    .push      (push),
    .rx_byte   (in_rx_byte),
    .cls_valid (cls_valid),
    .cls       (cls_in)
  );

  // queue between front and back; its fill level is what the pusher sees
  logic             mid_empty;
  logic             mid_take;
  logic [CLS_W-1:0] mid_data;

  rfd_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cls_valid),
    .wr_data (cls_in),
    .full    (full),
    .rd_en   (mid_take),
    .rd_data (mid_data),
    .empty   (mid_empty)
  );

  // back: frame parser, one byte per cycle when the result queue has room
  logic          res_full;
  logic          res_push;
  rfd_pkg::res_t res_in;
  rfd_pkg::res_t res_out;
  logic [RES_W-1:0] res_out_bits;

  rfd_back #(
    .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_avail (!mid_empty),
    .cls       (rfd_pkg::cls_t'(mid_data)),
    .cls_take  (mid_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .limits    (limits)
  );

  // result queue decouples the parser from the consumer
  rfd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out_bits),
    .empty   (empty)
  );

  assign res_out            = rfd_pkg::res_t'(res_out_bits);
  assign out_byte_kind      = res_out.kind;
  assign out_data_byte      = res_out.data;
  assign out_frame_done     = res_out.done;
  assign out_frame_status   = res_out.status;
  assign out_error_code     = res_out.error_code;
  assign out_payload_length = res_out.payload_length;

endmodule

/* sim/rpc_frame_deframer_unit_tb.sv */
module rpc_frame_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfd_pkg::*;

  // longest total length the parser accepts, also handed to the block
  localparam int unsigned MAX_FRAME = 65535;

  // ways a generated frame can be spoiled on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_BAD_END,
    FLAW_SHORT_LEN,
    FLAW_HUGE_LEN,
    FLAW_EMPTY_RID,
    FLAW_OVERRUN,
    FLAW_TRUNCATE,
    FLAW_GARBLE
  } frame_flaw_t;

  // tags every byte the way the deframer should, and holds the tags still due
  class frame_tag_checker;
    limits_t     limits;
    phase_t      phase;
    logic [15:0] frame_len;
    logic [15:0] frame_pos;
    logic [15:0] field_left;
    logic [31:0] shift_word;
    logic [31:0] ecode_word;
    logic [16:0] lens_total;
    status_t     held_status;
    res_t        tags_due[$];
    int unsigned fail_count;

    function new();
      limits      = {RST_MAX_RID, RST_MAX_SVC, RST_MAX_EI};
      phase       = PH_HUNT;
      frame_len   = '0;
      frame_pos   = '0;
      field_left  = '0;
      shift_word  = '0;
      ecode_word  = '0;
      lens_total  = '0;
      held_status = ST_OK;
      fail_count  = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_MAX_RID: limits.max_rid = value;
        REG_MAX_SVC: limits.max_svc = value;
        REG_MAX_EI:  limits.max_ei  = value;
        default: ;
      endcase
    endfunction

    // bytes still free for variable fields and payload
    function logic [31:0] room_left();
      return {16'd0, frame_len} - {16'd0, FIXED_BYTES} - {15'd0, lens_total};
    endfunction

    function void open_word(phase_t ph);
      phase      = ph;
      field_left = WORD_BYTES;
      shift_word = '0;
    endfunction

    function void open_payload();
      logic [31:0] n;
      n = room_left();
      if (n == 0) begin
        phase      = PH_CK;
        field_left = WORD_BYTES;
      end else begin
        phase      = PH_PAY;
        field_left = n[15:0];
      end
    endfunction

    // first failing check wins: empty, then overrun, then over the limit
    function status_t judge_length(logic [31:0] len, logic [15:0] cap, bit must_be_set);
      if (must_be_set && len == 0) return ST_EMPTY_RID;
      if (len > room_left()) return ST_OVERRUN;
      if (len > {16'd0, cap}) return ST_TOO_LONG;
      lens_total = lens_total + len[16:0];
      return ST_OK;
    endfunction

    function void tag_byte(logic [7:0] b);
      res_t        tag;
      status_t     verdict;
      logic [31:0] n;
      tag      = '0;
      tag.data = b;
      if (phase == PH_HUNT) begin
        if (b == START_BYTE) begin
          open_word(PH_LEN);
          frame_pos   = '0;
          frame_len   = '0;
          lens_total  = '0;
          held_status = ST_OK;
          ecode_word  = '0;
          tag.kind    = KIND_HEADER;
        end
      end else if (phase == PH_LEN) begin
        frame_pos  = frame_pos + 16'd1;
        tag.kind   = KIND_HEADER;
        shift_word = {shift_word[23:0], b};
        field_left = field_left - 16'd1;
        if (field_left == 0) begin
          if (shift_word < {16'd0, FIXED_BYTES} || shift_word > MAX_FRAME) begin
            // not a frame after all, hunt on from the next byte
            tag.done   = 1'b1;
            tag.status = ST_END_MISS;
            phase      = PH_HUNT;
          end else begin
            frame_len = shift_word[15:0];
            open_word(PH_RIDLEN);
          end
        end
      end else begin
        frame_pos = frame_pos + 16'd1;
        if ({16'd0, frame_pos} + 32'd1 >= {16'd0, frame_len}) begin
          // last byte of the frame, whatever phase we are in
          tag.kind = KIND_TRAILER;
          tag.done = 1'b1;
          if (held_status != ST_OK) tag.status = held_status;
          else if (b == END_BYTE) tag.status = ST_OK;
          else tag.status = ST_END_MISS;
          tag.error_code = ecode_word;
          n = room_left();
          if (tag.status == ST_OK) tag.payload_length = n[15:0];
          phase = PH_HUNT;
        end else begin
          case (phase)
            PH_RIDLEN, PH_SVCLEN, PH_ECODE, PH_EILEN: begin
              tag.kind   = KIND_HEADER;
              shift_word = {shift_word[23:0], b};
              field_left = field_left - 16'd1;
              if (field_left == 0) begin
                if (phase == PH_ECODE) begin
                  ecode_word = shift_word;
                  open_word(PH_EILEN);
                end else begin
                  if (phase == PH_RIDLEN)
                    verdict = judge_length(shift_word, limits.max_rid, 1'b1);
                  else if (phase == PH_SVCLEN)
                    verdict = judge_length(shift_word, limits.max_svc, 1'b0);
                  else
                    verdict = judge_length(shift_word, limits.max_ei, 1'b0);
                  if (verdict != ST_OK) begin
                    held_status = verdict;
                    phase       = PH_SKIP;
                  end else if (shift_word == 0) begin
                    if (phase == PH_SVCLEN) open_word(PH_ECODE);
                    else open_payload();
                  end else begin
                    field_left = shift_word[15:0];
                    if (phase == PH_RIDLEN) phase = PH_RID;
                    else if (phase == PH_SVCLEN) phase = PH_SVC;
                    else phase = PH_EI;
                  end
                end
              end
            end
            PH_RID, PH_SVC, PH_EI, PH_PAY: begin
              case (phase)
                PH_RID:  tag.kind = KIND_RID;
                PH_SVC:  tag.kind = KIND_SVC;
                PH_EI:   tag.kind = KIND_EI;
                default: tag.kind = KIND_PAYLOAD;
              endcase
              if (field_left != 0) field_left = field_left - 16'd1;
              if (field_left == 0) begin
                case (phase)
                  PH_RID:  open_word(PH_SVCLEN);
                  PH_SVC:  open_word(PH_ECODE);
                  PH_EI:   open_payload();
                  default: begin
                    phase      = PH_CK;
                    field_left = WORD_BYTES;
                  end
                endcase
              end
            end
            PH_CK: begin
              tag.kind = KIND_TRAILER;
              if (field_left != 0) field_left = field_left - 16'd1;
              if (field_left == 0) phase = PH_END;
            end
            default: tag.kind = KIND_TRAILER;
          endcase
        end
      end
      tags_due.push_back(tag);
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] data, logic done,
                               logic [2:0] status, logic [31:0] ecode, logic [15:0] plen);
      res_t want;
      if (tags_due.size() == 0) begin
        $error("item with no tag due: data_byte %02h", data);
        fail_count++;
        return;
      end
      want = tags_due.pop_front();
      if (kind !== want.kind) begin
        $error("byte_kind expected %0d actual %0d", want.kind, kind);
        fail_count++;
      end
      if (data !== want.data) begin
        $error("data_byte expected %02h actual %02h", want.data, data);
        fail_count++;
      end
      if (done !== want.done) begin
        $error("frame_done expected %0d actual %0d", want.done, done);
        fail_count++;
      end
      if (status !== want.status) begin
        $error("frame_status expected %0d actual %0d", want.status, status);
        fail_count++;
      end
      if (ecode !== want.error_code) begin
        $error("error_code expected %0d actual %0d",
               $signed(want.error_code), $signed(ecode));
        fail_count++;
      end
      if (plen !== want.payload_length) begin
        $error("payload_length expected %0d actual %0d", want.payload_length, plen);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_rx_byte;
  logic               pop;
  logic               empty;
  logic [2:0]         out_byte_kind;
  logic [7:0]         out_data_byte;
  logic               out_frame_done;
  logic [2:0]         out_frame_status;
  logic signed [31:0] out_error_code;
  logic [15:0]        out_payload_length;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  frame_tag_checker tagger;

  // bytes waiting to be pushed, front goes first
  logic [7:0] byte_stream[$];

  // per-cycle idle odds of each side, and a receiver hold-off in cycles
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 80;
  int unsigned hold_cycles   = 0;

  rpc_frame_deframer_unit #(.MAX_FRAME_LENGTH(MAX_FRAME)) dut (.*);

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: pops at random, or sits out a hold-off stretch when asked
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        pop <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every popped item is checked against the oldest tag due
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      tagger.check_result(out_byte_kind, out_data_byte, out_frame_done,
                          out_frame_status, out_error_code, out_payload_length);
  end

  // big-endian word, as on the wire
  function automatic void put_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) byte_stream.push_back(w[8*i +: 8]);
  endfunction

  function automatic void put_bytes(int unsigned n);
    repeat (n) byte_stream.push_back(8'($urandom));
  endfunction

  // one frame: start, length, three length-prefixed fields around the error
  // code, payload, checksum and end byte, then the chosen flaw if any
  function automatic void add_frame(int unsigned rid_n, int unsigned svc_n, int unsigned ei_n,
                                    int unsigned pay_n, logic [31:0] ecode,
                                    frame_flaw_t flaw);
    logic [31:0] total;
    logic [31:0] rid_w;
    logic [31:0] svc_w;
    logic [31:0] ei_w;
    int unsigned first;
    total = 32'(FIXED_BYTES) + rid_n + svc_n + ei_n + pay_n;
    rid_w = rid_n;
    svc_w = svc_n;
    ei_w  = ei_n;
    first = byte_stream.size();
    case (flaw)
      FLAW_EMPTY_RID: rid_w = '0;
      FLAW_SHORT_LEN: begin
        if ($urandom_range(1) == 0) total = 32'(FIXED_BYTES) - 1;
        else total = $urandom_range(24);
      end
      FLAW_HUGE_LEN: begin
        if ($urandom_range(1) == 0) total = MAX_FRAME + 1;
        else total = $urandom | 32'h0001_0000;
      end
      FLAW_OVERRUN: begin
        // declare a field longer than what is left of the frame, now and then the service field too
        case ($urandom_range(2))
          0: rid_w = rid_n + svc_n + ei_n + pay_n + 1 + $urandom_range(3);
          1: svc_w = svc_n + ei_n + pay_n + 1 + $urandom_range(3);
          default: ei_w = ei_n + pay_n + 1 + $urandom_range(3);
        endcase
        if ($urandom_range(3) == 0) svc_w = 32'hFFFF_FFFF;
      end
      default: ;
    endcase
    byte_stream.push_back(START_BYTE);
    put_word(total);
    put_word(rid_w);
    put_bytes(rid_n);
    put_word(svc_w);
    put_bytes(svc_n);
    put_word(ecode);
    put_word(ei_w);
    put_bytes(ei_n);
    put_bytes(pay_n);
    put_bytes(WORD_BYTES);
    if (flaw == FLAW_BAD_END) byte_stream.push_back(8'($urandom_range(255, 4)));
    else byte_stream.push_back(END_BYTE);
    // a cut frame swallows the start of whatever follows it
    if (flaw == FLAW_TRUNCATE)
      repeat ($urandom_range(8, 1)) void'(byte_stream.pop_back());
    if (flaw == FLAW_GARBLE)
      byte_stream[first + $urandom_range(byte_stream.size() - first - 1)] = 8'($urandom);
  endfunction

  // mostly short lengths within the limit, sometimes one past it
  function automatic int unsigned pick_len(int unsigned lo, int unsigned cap,
                                           int unsigned span);
    int unsigned hi;
    hi = (cap < span) ? cap : span;
    if (hi < lo) hi = lo;
    case ($urandom_range(9))
      0: return lo;
      1: begin
        if (cap < 40) return cap + 1;
        return $urandom_range(40, hi);
      end
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic void add_random_frame();
    int unsigned rid_n;
    int unsigned svc_n;
    int unsigned ei_n;
    int unsigned pay_n;
    int unsigned roll;
    frame_flaw_t flaw;
    rid_n = pick_len(1, tagger.limits.max_rid, 6);
    svc_n = pick_len(0, tagger.limits.max_svc, 10);
    ei_n  = pick_len(0, tagger.limits.max_ei, 8);
    pay_n = pick_len(0, 65535, 20);
    // about two frames in three are clean, the rest carry one flaw each
    roll = $urandom_range(19);
    if (roll < 13) flaw = FLAW_NONE;
    else flaw = frame_flaw_t'(roll - 12);
    add_frame(rid_n, svc_n, ei_n, pay_n, $urandom, flaw);
    // line noise between frames now and then
    if ($urandom_range(3) == 0) put_bytes($urandom_range(3, 1));
  endfunction

  // push everything queued in byte_stream, idling at random
  task automatic send_stream();
    logic [7:0] b;
    while (byte_stream.size() != 0) begin
      b = byte_stream[0];
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        push       <= 1'b0;
        in_rx_byte <= 8'($urandom);
      end else begin
        push       <= 1'b1;
        in_rx_byte <= b;
      end
      @(posedge clk);
      if (push && !full) begin
        tagger.tag_byte(in_rx_byte);
        void'(byte_stream.pop_front());
      end
    end
  endtask

  // stop pushing and wait until every tagged byte has come out
  task automatic drain_all();
    @(negedge clk);
    push <= 1'b0;
    while (tagger.tags_due.size() != 0) @(negedge clk);
    // extra margin after the last tag is checked
    repeat (4) @(negedge clk);
  endtask

  // register write, then read back
  task automatic write_limit(logic [1:0] idx, logic [15:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tagger.set_limit(idx, value);
    if (readback[15:0] !== value) begin
      $error("limit register %0d expected %0d actual %0d", idx, value, readback[15:0]);
      tagger.fail_count++;
    end
  endtask

  // main sequence
  initial begin
    limits_t     lims;
    int unsigned sent;
    rst_n      = 1'b0;
    push       = 1'b0;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    tagger     = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed frames, limits still at their reset values
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'hFF);
    byte_stream.push_back(END_BYTE);
    // shortest good frame: one request id byte, nothing else
    add_frame(1, 0, 0, 0, 32'h0000_0000, FLAW_NONE);
    // 26 bytes, empty request id
    add_frame(0, 0, 0, 0, 32'hFFFF_FFFF, FLAW_NONE);
    // request id right at its limit, most negative error code
    add_frame(49, 3, 2, 5, 32'h8000_0000, FLAW_NONE);
    add_frame(2, 0, 0, 1, 32'h7FFF_FFFF, FLAW_NONE);
    // request id one over its limit
    add_frame(50, 0, 0, 0, 32'h0000_0001, FLAW_NONE);
    add_frame(3, 4, 0, 0, 32'h1234_5678, FLAW_OVERRUN);
    add_frame(1, 1, 1, 1, 32'h0000_00FF, FLAW_BAD_END);
    add_frame(1, 0, 0, 0, 32'h0, FLAW_SHORT_LEN);
    add_frame(1, 0, 0, 0, 32'h0, FLAW_HUGE_LEN);
    add_frame(2, 2, 2, 2, 32'hDEAD_BEEF, FLAW_TRUNCATE);
    add_frame(1, 2, 3, 0, 32'hCAFE_F00D, FLAW_NONE);
    send_stream();
    drain_all();

    // six random rounds, two per idling mix, each with its own limits
    for (int r = 0; r < 6; r++) begin
      if (r < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 80;
      end else if (r < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (r)
        0: lims = {RST_MAX_RID, RST_MAX_SVC, RST_MAX_EI};
        1: lims = {16'd1, 16'd1, 16'd0};
        2, 3: lims = {16'($urandom_range(30, 1)), 16'($urandom_range(40, 1)),
                      16'($urandom_range(20, 0))};
        4: lims = {16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                   16'($urandom)};
        default: lims = {16'hFFFF, 16'hFFFF, 16'hFFFF};
      endcase
      write_limit(REG_MAX_RID, lims.max_rid);
      write_limit(REG_MAX_SVC, lims.max_svc);
      write_limit(REG_MAX_EI, lims.max_ei);

      // long receiver hold-off while the sender keeps offering bytes
      if (r == 1) hold_cycles = 400;

      sent = 0;
      while (sent < 190) begin
        add_random_frame();
        sent += byte_stream.size();
        send_stream();
        // sender waits for the pipe to empty now and then
        if ($urandom_range(11) == 0) drain_all();
      end
      drain_all();
    end

    if (tagger.fail_count == 0 && tagger.tags_due.size() == 0)
      $display("[rpc_frame_deframer_unit] OK");
    else
      $display("[rpc_frame_deframer_unit] ERROR");
    $finish;
  end

  // watchdog, well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("[rpc_frame_deframer_unit] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rfd_pkg.sv
rtl/core/rfd_fifo.sv
rtl/core/rfd_front.sv
rtl/core/rfd_back.sv
rtl/core/rpc_frame_deframer_unit.sv
sim/rpc_frame_deframer_unit_tb.sv
